### hdl/olad_pkg.sv
// ---------------------------------------------------------------------------
// olad_pkg: shared types and constants for the ordered list block
// Holds the list depth, the command and status codes, the command and
// response beat structs, and the control struct handed to each list cell.
// ---------------------------------------------------------------------------
package olad_pkg;

    // Number of list cells.
    localparam int DEPTH = 16;

    // Derived widths.
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int POS_W  = 4;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;
    localparam int WIDE_W = (FILL_W > CNT_W) ? FILL_W : CNT_W;

    // Command codes.
    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BEYOND    = 2'd3;

    // Command beat.
    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } cmd_t;

    // Response beat.
    typedef struct packed {
        logic [1:0]               status;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

    // Per-cell control for one command.
    typedef struct packed {
        logic append;   // This cell is the tail slot and takes the value.
        logic search;   // A delete is in progress.
        logic in_list;  // This cell holds a live entry.
    } cell_ctl_t;

endpackage

### hdl/olad_cell.sv
// ---------------------------------------------------------------------------
// olad_cell: one list cell
// Holds one entry, compares it with the command value, passes the match
// chain on toward the tail, and on a delete at or after the first match
// takes the entry of its tailward neighbor to close the gap.
// ---------------------------------------------------------------------------
module olad_cell
    import olad_pkg::*;
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] next_entry,
    input  logic                     hit_in,
    output logic                     hit_out,
    output logic signed [DATA_W-1:0] entry
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     match;

    // Match chain: set from the first live entry equal to the value onward.
    assign match   = ctl.search && ctl.in_list && (entry_reg == value);
    assign hit_out = hit_in || match;

    // Next entry: append writes the tail slot, a delete shifts toward the head.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.append)
        begin
            entry_next = value;
        end
        else if (ctl.search && hit_out)
        begin
            entry_next = next_entry;
        end
    end

    // Entry storage needs no reset; it is undefined until written.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### hdl/ordered_list_append_delete.sv
// ---------------------------------------------------------------------------
// ordered_list_append_delete: bounded ordered list with append and delete
// Keeps up to DEPTH signed 32-bit entries head first in a row of cells and
// answers append, delete-first-match and read-by-position commands.
// ---------------------------------------------------------------------------
// The block takes one command per clock: busy never rises, and each command
// accepted on a rising edge with start high gets its response in the next
// cycle, shown for exactly that cycle with done high. The receiver cannot
// stall, so a response must be captured in the cycle it appears. The speed
// is set by the row of cells, where every entry is compared at once and a
// delete shifts all later entries one place toward the head in the same
// cycle; the match chain that ripples through the row is the longest path.
module ordered_list_append_delete
    import olad_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    logic                     accept;
    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;
    logic                     done_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     full;
    logic                     found;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         fill_ext;
    logic [WIDE_W-1:0]        fill_wide;
    logic signed [DATA_W-1:0] cell_entry [DEPTH];
    logic                     hit_chain [DEPTH+1];
    cell_ctl_t                cell_ctl [DEPTH];

    // The list takes a command every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (fill_reg == FILL_W'(DEPTH));

    // Row of cells with the match chain running from head to tail.
    assign hit_chain[0] = 1'b0;
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_ctl[i].append  = accept && (cmd.func == FN_APPEND) && !full
                                     && (fill_reg == FILL_W'(i));
        assign cell_ctl[i].search  = accept && (cmd.func == FN_DELETE);
        assign cell_ctl[i].in_list = (FILL_W'(i) < fill_reg);

        olad_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .value      (cmd.value),
            .next_entry ((i == DEPTH - 1) ? cell_entry[i] : cell_entry[(i + 1) % DEPTH]),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .entry      (cell_entry[i])
        );
    end

    assign found    = hit_chain[DEPTH];
    assign pos_ext  = CMP_W'(cmd.position);
    assign fill_ext = CMP_W'(fill_reg);

    // Command decode: new fill and the response beat.
    always_comb
    begin
        fill_next           = fill_reg;
        rsp_next.status     = ST_OK;
        rsp_next.read_value = '0;
        if (accept)
        begin
            unique case (cmd.func)
                FN_APPEND:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                FN_DELETE:
                begin
                    if (found)
                    begin
                        fill_next = fill_reg - FILL_W'(1);
                    end
                    else
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                end
                FN_READ:
                begin
                    if ((pos_ext >= fill_ext) || (pos_ext >= CMP_W'(DEPTH)))
                    begin
                        rsp_next.status = ST_BEYOND;
                    end
                    else
                    begin
                        rsp_next.read_value = cell_entry[pos_ext[IDX_W-1:0]];
                    end
                end
                default:
                begin
                    // Unused command code: no change, status ok.
                    rsp_next.status = ST_OK;
                end
            endcase
        end
        fill_wide      = WIDE_W'(fill_next);
        rsp_next.count = fill_wide[CNT_W-1:0];
    end

    // Fill count and response strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= accept;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // The fill count never exceeds the number of cells.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count above depth");

    // Each accepted command yields exactly one response in the next cycle.
    a_one_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing response");
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("response without command");

    // A successful delete shrinks the list by one.
    a_delete_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.func == FN_DELETE) && found)
        |=> (fill_reg == $past(fill_reg) - FILL_W'(1)))
        else $error("delete did not shrink the list");

endmodule
